>>> sv/pls_pkg.sv
// Package for the positional list store: sizes, status codes and payload types.
// Used by pls_ram's users and by positional_list_store_core; depends on nothing.

package pls_pkg;

  // Store size and the widths that follow from it.
  localparam int LIST_CAPACITY = 256;
  localparam int ADDR_W        = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
  localparam int COUNT_W       = $clog2(LIST_CAPACITY + 1);

  // Fixed field widths of the request and response.
  localparam int POS_W  = 16;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;
  localparam int LEN_W  = 9;

  // Width used to compare a position against the element count.
  localparam int CMP_W = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Response status codes.
  localparam logic [STAT_W-1:0] STS_DONE     = 3'd0;
  localparam logic [STAT_W-1:0] STS_APPENDED = 3'd1;
  localparam logic [STAT_W-1:0] STS_NEGATIVE = 3'd2;
  localparam logic [STAT_W-1:0] STS_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] STS_PAST_END = 3'd4;
  localparam logic [STAT_W-1:0] STS_FULL     = 3'd5;

  // Request payload.
  typedef struct packed {
    logic                     operation;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  // Response payload.
  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         length;
  } rsp_t;

endpackage

>>> sv/pls_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Self-contained; no package is needed.

module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/positional_list_store_core.sv
// Positional list store: top level with the edit sequencer and the element RAM.
// Depends on pls_pkg and pls_ram.

// The block holds an ordered list of up to LIST_CAPACITY signed 32-bit words and edits it one
// request at a time: insert a value at a zero-based position, or remove the element at a
// position, returning it. Each request gives exactly one response with a status code and the
// list length afterwards. Requests that touch only one slot or are rejected go straight to
// S_DONE. An insert that lands inside the list first walks S_SHUP and then writes in S_FILL,
// and a remove walks S_SHDN, because the elements behind the position move one place per
// cycle through the single write port of the element RAM. The request side stalls
// while an edit is in progress; a finished response may wait in the output register while the
// next request is taken. The element RAM needs no clearing after reset.

module positional_list_store_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pls_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pls_pkg::rsp_t rsp
);

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SHUP = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_SHDN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [pls_pkg::COUNT_W-1:0] COUNT_FULL =
    pls_pkg::COUNT_W'(pls_pkg::LIST_CAPACITY);
  localparam logic [pls_pkg::COUNT_W-1:0] COUNT_ONE = pls_pkg::COUNT_W'(1);
  localparam logic [pls_pkg::ADDR_W-1:0]  ADDR_ONE  = pls_pkg::ADDR_W'(1);

  logic [2:0]                       state, state_next;
  logic [pls_pkg::COUNT_W-1:0]      count, count_next;
  logic [pls_pkg::ADDR_W-1:0]       idx, idx_next;
  logic [pls_pkg::ADDR_W-1:0]       lo, lo_next;
  logic [pls_pkg::DATA_W-1:0]       val, val_next;
  logic [pls_pkg::DATA_W-1:0]       taken, taken_next;
  logic [pls_pkg::STAT_W-1:0]       status, status_next;

  logic                             ram_we;
  logic [pls_pkg::ADDR_W-1:0]       ram_waddr;
  logic [pls_pkg::DATA_W-1:0]       ram_wdata;
  logic [pls_pkg::ADDR_W-1:0]       ram_raddr;
  logic [pls_pkg::DATA_W-1:0]       ram_rdata;

  logic                             accept;
  logic                             pos_neg;
  logic [pls_pkg::CMP_W-1:0]        pos_ext;
  logic                             pos_past;
  logic [pls_pkg::COUNT_W-1:0]      count_dec;
  logic [pls_pkg::ADDR_W-1:0]       last_addr;
  logic [pls_pkg::ADDR_W-1:0]       idx_inc;
  logic [pls_pkg::ADDR_W-1:0]       idx_dec;
  logic                             rsp_free;

  // Element storage.
  pls_ram #(
    .WIDTH(pls_pkg::DATA_W),
    .DEPTH(pls_pkg::LIST_CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Request decode and shared index arithmetic.
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && (state == S_IDLE);
  assign pos_neg   = req.position[pls_pkg::POS_W-1];
  assign pos_ext   = pls_pkg::CMP_W'(req.position[pls_pkg::POS_W-2:0]);
  assign pos_past  = (pos_ext >= pls_pkg::CMP_W'(count));
  assign count_dec = count - COUNT_ONE;
  assign last_addr = pls_pkg::ADDR_W'(count_dec);
  assign idx_inc   = idx + ADDR_ONE;
  assign idx_dec   = idx - ADDR_ONE;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Sequencer: decides each request, then walks the elements behind the position.
  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    lo_next     = lo;
    val_next    = val;
    taken_next  = taken;
    status_next = status;
    ram_we      = 1'b0;
    ram_waddr   = idx;
    ram_wdata   = ram_rdata;
    ram_raddr   = idx;

    case (state)
      S_IDLE: begin
        if (accept) begin
          taken_next = '0;
          val_next   = req.value;
          state_next = S_DONE;
          if (req.operation == pls_pkg::OP_INSERT) begin
            if (pos_neg) begin
              status_next = pls_pkg::STS_NEGATIVE;
            end else if (count == COUNT_FULL) begin
              status_next = pls_pkg::STS_FULL;
            end else if (count == '0) begin
              ram_we      = 1'b1;
              ram_waddr   = '0;
              ram_wdata   = req.value;
              count_next  = COUNT_ONE;
              status_next = pls_pkg::STS_DONE;
            end else if (pos_past) begin
              ram_we      = 1'b1;
              ram_waddr   = pls_pkg::ADDR_W'(count);
              ram_wdata   = req.value;
              count_next  = count + COUNT_ONE;
              status_next = pls_pkg::STS_APPENDED;
            end else begin
              // Start moving the tail up from the last element.
              ram_raddr  = last_addr;
              idx_next   = last_addr;
              lo_next    = pls_pkg::ADDR_W'(pos_ext);
              state_next = S_SHUP;
            end
          end else begin
            if (count == '0) begin
              status_next = pls_pkg::STS_EMPTY;
            end else if (pos_neg) begin
              status_next = pls_pkg::STS_NEGATIVE;
            end else if (pos_past) begin
              status_next = pls_pkg::STS_PAST_END;
            end else begin
              // Read the element to remove first, then pull the tail down.
              ram_raddr  = pls_pkg::ADDR_W'(pos_ext);
              idx_next   = pls_pkg::ADDR_W'(pos_ext);
              lo_next    = pls_pkg::ADDR_W'(pos_ext);
              state_next = S_SHDN;
            end
          end
        end
      end

      S_SHUP: begin
        // The word read from idx moves to idx + 1.
        ram_we    = 1'b1;
        ram_waddr = idx_inc;
        ram_wdata = ram_rdata;
        ram_raddr = idx_dec;
        if (idx == lo) begin
          state_next = S_FILL;
        end else begin
          idx_next = idx_dec;
        end
      end

      S_FILL: begin
        ram_we      = 1'b1;
        ram_waddr   = lo;
        ram_wdata   = val;
        count_next  = count + COUNT_ONE;
        status_next = pls_pkg::STS_DONE;
        state_next  = S_DONE;
      end

      S_SHDN: begin
        // The first word read is the one removed; later ones move to idx - 1.
        ram_raddr = idx_inc;
        if (idx == lo) begin
          taken_next = ram_rdata;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = idx_dec;
          ram_wdata = ram_rdata;
        end
        if (idx == last_addr) begin
          count_next  = count_dec;
          status_next = pls_pkg::STS_DONE;
          state_next  = S_DONE;
        end else begin
          idx_next = idx_inc;
        end
      end

      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    lo     <= lo_next;
    val    <= val_next;
    taken  <= taken_next;
    status <= status_next;
  end

  // Response register: loaded as a request finishes, cleared by a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && rsp_free) begin
      rsp.removed_value <= taken;
      rsp.status        <= status;
      rsp.length        <= pls_pkg::LEN_W'(count);
    end
  end

  // The element count never exceeds the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("element count exceeds capacity");

  // Walking the list only happens with a non-empty list.
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHUP || state == S_SHDN) |-> count != '0)
    else $error("shift sequence running on an empty list");

  // A new response only appears after the sequencer has finished a request.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside the finishing state");

  // Responses with a status other than done carry a zero removed value.
  a_zero_taken: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != pls_pkg::STS_DONE) |-> rsp.removed_value == '0)
    else $error("non-zero removed value on a response without removal");

  // An edit inside the list keeps its position within the list.
  a_lo_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHUP || state == S_SHDN) |-> lo <= last_addr)
    else $error("edit position beyond the last element");

endmodule

>>> sim/pls_edit_checker.sv
`timescale 1ns / 1ps
// Checker for the positional list store: watches both channels, predicts every response
// and compares it. Depends on pls_pkg for the payload types, sizes and codes.

module pls_edit_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  pls_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  pls_pkg::rsp_t rsp,
  output int            fault_count,
  output int            pending_edits
);

  // Shadow copy of the list contents, slot 0 at the front.
  logic signed [pls_pkg::DATA_W-1:0] list_image[$];
  // Responses still owed by the block, oldest first.
  pls_pkg::rsp_t                     awaited_rsp[$];
  pls_pkg::rsp_t                     oldest;

  // Applies one edit to the shadow list and returns the response it must produce.
  function automatic pls_pkg::rsp_t predict_edit(input pls_pkg::req_t edit);
    pls_pkg::rsp_t outcome;
    int            slot;
    int            fill;
    slot                  = int'(edit.position);
    fill                  = list_image.size();
    outcome.removed_value = '0;
    if (edit.operation == pls_pkg::OP_INSERT) begin
      if (slot < 0) begin
        outcome.status = pls_pkg::STS_NEGATIVE;
      end else if (fill >= pls_pkg::LIST_CAPACITY) begin
        outcome.status = pls_pkg::STS_FULL;
      end else if (fill == 0) begin
        // An empty list takes the value at its head whatever the non-negative position.
        list_image.push_back(edit.value);
        outcome.status = pls_pkg::STS_DONE;
      end else if (slot >= fill) begin
        list_image.push_back(edit.value);
        outcome.status = pls_pkg::STS_APPENDED;
      end else begin
        list_image.insert(slot, edit.value);
        outcome.status = pls_pkg::STS_DONE;
      end
    end else begin
      // Emptiness is judged before the sign of the position.
      if (fill == 0) begin
        outcome.status = pls_pkg::STS_EMPTY;
      end else if (slot < 0) begin
        outcome.status = pls_pkg::STS_NEGATIVE;
      end else if (slot >= fill) begin
        outcome.status = pls_pkg::STS_PAST_END;
      end else begin
        outcome.removed_value = list_image[slot];
        list_image.delete(slot);
        outcome.status = pls_pkg::STS_DONE;
      end
    end
    outcome.length = pls_pkg::LEN_W'(list_image.size());
    return outcome;
  endfunction

  // Responses are checked before the request of the same edge is predicted, as a
  // response can never belong to a request taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      list_image.delete();
      awaited_rsp.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("unexpected response transfer: value %0d status %0d length %0d",
                     rsp.removed_value, rsp.status, rsp.length);
          end
        end else begin
          oldest = awaited_rsp.pop_front();
          if (rsp.removed_value !== oldest.removed_value || rsp.status !== oldest.status ||
              rsp.length !== oldest.length) begin
            fault_count++;
            if (fault_count <= 10) begin
              $display({"response mismatch: expected value %0d status %0d length %0d,",
                        " got value %0d status %0d length %0d"},
                       oldest.removed_value, oldest.status, oldest.length,
                       rsp.removed_value, rsp.status, rsp.length);
            end
          end
        end
      end
      if (req_valid && !req_stall) begin
        awaited_rsp.push_back(predict_edit(req));
      end
    end
    pending_edits = awaited_rsp.size();
  end

endmodule

>>> sim/tb_positional_list_store_core.sv
`timescale 1ns / 1ps
// Testbench top for positional_list_store_core: clock, reset, request and stall stimulus,
// and the verdict. Depends on pls_pkg, the block itself and pls_edit_checker.

module tb_positional_list_store_core;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 300;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      req_valid   = 1'b0;
  logic                      req_stall;
  pls_pkg::req_t             req         = '0;
  logic                      rsp_valid;
  logic                      rsp_stall   = 1'b0;
  pls_pkg::rsp_t             rsp;

  int                        fault_count;
  int                        pending_edits;
  int                        cycle_count = 0;
  logic [pls_pkg::LEN_W-1:0] seen_length = '0;
  bit                        calm        = 1'b0;
  int                        gap_pct     = 0;
  int                        stall_hold  = 0;
  bit                        stall_burst = 1'b0;

  positional_list_store_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  pls_edit_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp),
    .fault_count   (fault_count),
    .pending_edits (pending_edits)
  );

  always #5 clk = ~clk;

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_positional_list_store_core: errors");
      $finish;
    end
  end

  // Track the most recent list length so that positions can be aimed at the list.
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall) begin
      seen_length <= rsp.length;
    end
  end

  // Response stall: stalled bursts of random length mixed with free runs of varied length.
  always @(negedge clk) begin
    if (calm) begin
      rsp_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_burst = ($urandom_range(0, 99) < 35);
        if (stall_burst) begin
          stall_hold = $urandom_range(1, 11);
        end else if ($urandom_range(0, 9) == 0) begin
          stall_hold = $urandom_range(100, 400);
        end else begin
          stall_hold = $urandom_range(1, 30);
        end
      end
      stall_hold--;
      rsp_stall <= stall_burst;
    end
  end

  // Offers one request and returns at the falling edge after its transfer, valid still high.
  task automatic send_edit(input logic op, input logic signed [pls_pkg::POS_W-1:0] pos,
                           input logic signed [pls_pkg::DATA_W-1:0] val);
    int gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap       = $urandom_range(1, 11);
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.operation = op;
    req.position  = pos;
    req.value     = val;
    req_valid     = 1'b1;
    do begin
      @(posedge clk);
    end while (req_stall);
    @(negedge clk);
  endtask

  // Positions mostly land inside or just past the list, with some far off and negative.
  function automatic logic signed [pls_pkg::POS_W-1:0] pick_position();
    int span;
    int pick;
    span = int'(seen_length);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return pls_pkg::POS_W'($urandom_range(0, span));
    end else if (pick < 70) begin
      return '0;
    end else if (pick < 78) begin
      return pls_pkg::POS_W'((span > 0) ? span - 1 : 0);
    end else if (pick < 86) begin
      return pls_pkg::POS_W'($urandom_range(span, 32767));
    end else if (pick < 95) begin
      return {1'b1, 15'($urandom)};
    end else begin
      case ($urandom_range(0, 2))
        0:       return 16'sh8000;
        1:       return 16'sh7fff;
        default: return -16'sd1;
      endcase
    end
  endfunction

  function automatic logic signed [pls_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) != 0) begin
      return $urandom;
    end
    case ($urandom_range(0, 3))
      0:       return 32'sh0;
      1:       return -32'sd1;
      2:       return 32'sh7fffffff;
      default: return 32'sh80000000;
    endcase
  endfunction

  // A run of random edits; the share of inserts steers the list towards full or empty.
  task automatic run_phase(input int items, input int insert_pct);
    logic op;
    for (int n = 0; n < items; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 12;
          default: gap_pct = 50;
        endcase
      end
      op = ($urandom_range(0, 99) < insert_pct) ? pls_pkg::OP_INSERT : pls_pkg::OP_REMOVE;
      send_edit(op, pick_position(), pick_value());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: rejections on an empty list, then edits at the head, middle and tail.
    send_edit(pls_pkg::OP_REMOVE, 16'sd3, 32'sd0);
    send_edit(pls_pkg::OP_REMOVE, -16'sd5, 32'sd0);
    send_edit(pls_pkg::OP_INSERT, -16'sd1, 32'sd11);
    send_edit(pls_pkg::OP_INSERT, 16'sd100, 32'sd1);
    send_edit(pls_pkg::OP_INSERT, 16'sd5, 32'sd2);
    send_edit(pls_pkg::OP_INSERT, 16'sd2, 32'sd3);
    send_edit(pls_pkg::OP_INSERT, 16'sd0, 32'sd4);
    send_edit(pls_pkg::OP_INSERT, 16'sd1, -32'sd5);
    send_edit(pls_pkg::OP_INSERT, 16'sh7fff, 32'sh7fffffff);
    send_edit(pls_pkg::OP_INSERT, 16'sd0, 32'sh80000000);
    send_edit(pls_pkg::OP_REMOVE, 16'sh8000, 32'sd7);
    send_edit(pls_pkg::OP_REMOVE, 16'sh7fff, 32'sd0);
    send_edit(pls_pkg::OP_REMOVE, 16'sd7, 32'sd0);
    send_edit(pls_pkg::OP_REMOVE, 16'sd0, 32'sd0);
    send_edit(pls_pkg::OP_REMOVE, 16'sd5, 32'sd0);
    send_edit(pls_pkg::OP_REMOVE, 16'sd2, 32'sd0);
    // Drain to empty, the last removal taking the sole element.
    repeat (4) send_edit(pls_pkg::OP_REMOVE, 16'sd0, -32'sd1);
    send_edit(pls_pkg::OP_INSERT, 16'sd0, -32'sd1);
    send_edit(pls_pkg::OP_INSERT, 16'sd1, 32'sd0);
    send_edit(pls_pkg::OP_REMOVE, 16'sd1, 32'sh7fffffff);

    // Random: fill until the store is full, empty it again, then a balanced tail.
    run_phase(350, 95);
    run_phase(330, 10);
    calm = 1'b1;
    run_phase(300, 55);
    req_valid = 1'b0;

    while (pending_edits != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_count == 0 && pending_edits == 0) begin
      $display("tb_positional_list_store_core: clean");
    end else begin
      $display("tb_positional_list_store_core: errors");
    end
    $finish;
  end

endmodule
